FILE: hdl/vefm_pkg.sv
// ----------------------------------------------------------------------------
// vefm_pkg
// Shared types and constants for the voxel exposed-face mask block.
// ----------------------------------------------------------------------------
`default_nettype none

package vefm_pkg;

    localparam int COORD_W   = 6;
    localparam int COORD_SPAN = 64;
    localparam int NB_W      = COORD_W + 1;
    localparam int FACE_N    = 6;
    localparam int S_DATA_W  = 24;
    localparam int S_USER_W  = 1;
    localparam int M_DATA_W  = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int FACE_PX = 0;
    localparam int FACE_NX = 1;
    localparam int FACE_PY = 2;
    localparam int FACE_NY = 3;
    localparam int FACE_PZ = 4;
    localparam int FACE_NZ = 5;

    // read sequence of a query: own row, then +x, -x, +y, -y rows
    localparam logic [2:0] RD_OWN  = 3'd0;
    localparam logic [2:0] RD_PX   = 3'd1;
    localparam logic [2:0] RD_NX   = 3'd2;
    localparam logic [2:0] RD_PY   = 3'd3;
    localparam logic [2:0] RD_NY   = 3'd4;
    localparam logic [2:0] RD_LAST = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_Q_RD,
        ST_Q_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/voxel_exposed_face_mask.sv
// ----------------------------------------------------------------------------
// voxel_exposed_face_mask
// Occupancy grid in one row memory (one row per x,y; bit z per voxel);
// writes set or clear one voxel, queries return occupancy and face mask.
// ----------------------------------------------------------------------------
// Write: accept, then read (ST_WR_RD) and write-back (ST_WR_WB), then idle again.
// Query: accept, then row reads on the single memory port
//   (own row, +x, -x, +y, -y), then an output state that waits for the output slot.
// Reset: a clearing pass writes every row to zero, one row per cycle,
//   over (2^clog2(min(GRID_SIDE,64)))^2 rows (4096 at the default); no word is
//   taken until it ends.
`default_nettype none

module voxel_exposed_face_mask #(
    parameter int GRID_SIDE = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [5:0] voxel_x, [11:6] voxel_y, [17:12] voxel_z, [18] set_solid
    input  wire logic [vefm_pkg::S_DATA_W-1:0] i_s_tdata,
    // [0] opcode
    input  wire logic [vefm_pkg::S_USER_W-1:0] i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [0] is_solid, [6:1] face_mask
    output logic [vefm_pkg::M_DATA_W-1:0]      o_m_tdata
);
    import vefm_pkg::*;

    localparam int SIDE_EFF = (GRID_SIDE < COORD_SPAN) ? GRID_SIDE : COORD_SPAN;
    localparam int AW       = $clog2(SIDE_EFF);
    localparam int DEPTH    = 1 << (2 * AW);
    localparam logic [NB_W-1:0] SIDE_LIM = NB_W'(SIDE_EFF);

    t_state r_state, n_state;

    logic [SIDE_EFF-1:0] r_mem [DEPTH];
    logic [SIDE_EFF-1:0] r_rd_data;
    logic [2*AW-1:0]     r_clr;
    logic [2:0]          r_step;
    logic [NB_W-1:0]     r_x, r_y, r_z;
    logic                r_set;
    logic                r_solid;
    logic [FACE_N-1:0]   r_mask;
    logic                r_out_valid;
    logic                r_out_solid;
    logic [FACE_N-1:0]   r_out_mask;

    logic                s_accept;
    logic                out_load;
    logic                mem_we;
    logic [2*AW-1:0]     mem_waddr;
    logic [2*AW-1:0]     mem_raddr;
    logic [SIDE_EFF-1:0] mem_wdata;
    logic [SIDE_EFF-1:0] z_bit;
    logic [NB_W-1:0]     rd_x, rd_y;
    logic [NB_W-1:0]     xp, xm, yp, ym, zp, zm;

    function automatic logic f_in(input logic [NB_W-1:0] a, input logic [NB_W-1:0] b,
                                  input logic [NB_W-1:0] c);
        f_in = (a < SIDE_LIM) && (b < SIDE_LIM) && (c < SIDE_LIM);
    endfunction

    assign xp = r_x + NB_W'(1);
    assign xm = r_x - NB_W'(1);
    assign yp = r_y + NB_W'(1);
    assign ym = r_y - NB_W'(1);
    assign zp = r_z + NB_W'(1);
    assign zm = r_z - NB_W'(1);

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_load = (r_state == ST_Q_OUT) && (!r_out_valid || i_m_tready);
    assign z_bit    = SIDE_EFF'(1) << r_z[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_accept) n_state = (i_s_tuser[0] == OP_WRITE) ? ST_WR_RD : ST_Q_RD;
            end
            ST_WR_RD: n_state = ST_WR_WB;
            ST_WR_WB: n_state = ST_IDLE;
            ST_Q_RD: begin
                if (r_step == RD_LAST) n_state = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb begin
        o_s_tready = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = {r_x[AW-1:0], r_y[AW-1:0]};
        mem_wdata  = r_set ? (r_rd_data | z_bit) : (r_rd_data & ~z_bit);
        rd_x       = r_x;
        rd_y       = r_y;
        unique case (r_step)
            RD_PX:   rd_x = xp;
            RD_NX:   rd_x = xm;
            RD_PY:   rd_y = yp;
            RD_NY:   rd_y = ym;
            default: rd_x = r_x;
        endcase
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            ST_IDLE:  o_s_tready = 1'b1;
            ST_WR_WB: mem_we = f_in(r_x, r_y, r_z);
            default:  mem_we = 1'b0;
        endcase
        mem_raddr = {rd_x[AW-1:0], rd_y[AW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_step      <= RD_OWN;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (s_accept) begin
                r_step <= RD_OWN;
            end else if (r_state == ST_Q_RD) begin
                r_step <= r_step + 3'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and neighbor capture; word k of the read sequence lands at step k+1
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x     <= NB_W'(i_s_tdata[5:0]);
            r_y     <= NB_W'(i_s_tdata[11:6]);
            r_z     <= NB_W'(i_s_tdata[17:12]);
            r_set   <= i_s_tdata[18];
            r_solid <= 1'b0;
            r_mask  <= '1;
        end else if (r_state == ST_Q_RD) begin
            unique case (r_step)
                RD_OWN + 3'd1: begin
                    r_solid <= f_in(r_x, r_y, r_z) && r_rd_data[r_z[AW-1:0]];
                    if (f_in(r_x, r_y, zp) && r_rd_data[zp[AW-1:0]]) r_mask[FACE_PZ] <= 1'b0;
                    if (f_in(r_x, r_y, zm) && r_rd_data[zm[AW-1:0]]) r_mask[FACE_NZ] <= 1'b0;
                end
                RD_PX + 3'd1: begin
                    if (f_in(xp, r_y, r_z) && r_rd_data[r_z[AW-1:0]]) r_mask[FACE_PX] <= 1'b0;
                end
                RD_NX + 3'd1: begin
                    if (f_in(xm, r_y, r_z) && r_rd_data[r_z[AW-1:0]]) r_mask[FACE_NX] <= 1'b0;
                end
                RD_PY + 3'd1: begin
                    if (f_in(r_x, yp, r_z) && r_rd_data[r_z[AW-1:0]]) r_mask[FACE_PY] <= 1'b0;
                end
                RD_NY + 3'd1: begin
                    if (f_in(r_x, ym, r_z) && r_rd_data[r_z[AW-1:0]]) r_mask[FACE_NY] <= 1'b0;
                end
                default: r_mask <= r_mask;
            endcase
        end
        if (out_load) begin
            r_out_solid <= r_solid;
            r_out_mask  <= r_mask;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_mask, r_out_solid};

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_m_tvalid)
        else $error("result word during clearing pass");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == ST_Q_OUT))
        else $error("result word not caused by a query");

    a_no_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_RD || r_state == ST_Q_OUT) |-> !mem_we)
        else $error("memory write during query");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_RD) |-> (r_step <= RD_LAST))
        else $error("query read step out of range");

endmodule

`default_nettype wire

FILE: tb/tb_voxel_exposed_face_mask.sv
// ----------------------------------------------------------------------------
// tb_voxel_exposed_face_mask
// Self-checking bench for the voxel exposed-face mask block. A directed table
// covers grid corners, a fully enclosed voxel and faces opened one by one. A
// long random run follows, mostly in small clusters so that neighbors are
// often solid. Query results are checked against a local occupancy grid or fixed table values.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voxel_exposed_face_mask;

    timeunit 1ns;
    timeprecision 1ps;

    import vefm_pkg::*;

    localparam int GRID         = 64;
    localparam int RANDOM_WORDS = 1530;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 20000;

    // packed from the top bit down: face_mask in [6:1], is_solid in [0]
    typedef struct packed {
        logic [5:0] face_mask;
        logic       is_solid;
    } t_face_result;

    typedef struct {
        logic       op;
        int         x;
        int         y;
        int         z;
        logic       solid;
        bit         fixed;
        logic       e_solid;
        logic [5:0] e_mask;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tready = 1'b0;
    logic                o_s_tready;
    logic                o_m_tvalid;
    logic [M_DATA_W-1:0] o_m_tdata;

    logic [63:0]  occ_rows [GRID*GRID];
    t_face_result expected_faces [$];
    int           faults = 0;
    int           results_seen = 0;
    int           words_sent = 0;
    int           idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    voxel_exposed_face_mask #(
        .GRID_SIDE (GRID)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    function automatic bit voxel_solid_at(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x >= GRID || y >= GRID || z >= GRID || z >= 64)
            return 1'b0;
        return occ_rows[x*GRID + y][z];
    endfunction

    function automatic t_face_result predict_faces(int x, int y, int z);
        t_face_result r;
        r.is_solid           = voxel_solid_at(x, y, z);
        r.face_mask[FACE_PX] = !voxel_solid_at(x + 1, y, z);
        r.face_mask[FACE_NX] = !voxel_solid_at(x - 1, y, z);
        r.face_mask[FACE_PY] = !voxel_solid_at(x, y + 1, z);
        r.face_mask[FACE_NY] = !voxel_solid_at(x, y - 1, z);
        r.face_mask[FACE_PZ] = !voxel_solid_at(x, y, z + 1);
        r.face_mask[FACE_NZ] = !voxel_solid_at(x, y, z - 1);
        return r;
    endfunction

    function automatic void store_voxel(int x, int y, int z, logic solid);
        if (x < GRID && y < GRID && z < GRID && z < 64)
            occ_rows[x*GRID + y][z] = solid;
    endfunction

    function automatic void note_fault(string msg);
        if (faults < 10)
            $display("MISMATCH: %s", msg);
        faults++;
    endfunction

    function automatic int pick_base();
        int r;
        r = $urandom_range(0, 4);
        if (r == 0)
            return 0;
        if (r == 1)
            return 60;
        return $urandom_range(0, 60);
    endfunction

    task automatic send_word(input logic op, input int x, input int y, input int z,
                             input logic solid, input bit fixed, input t_face_result fixed_res);
        int gap;
        gap = ((words_sent % 200) < 40) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, solid, 6'(z), 6'(y), 6'(x)};
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        words_sent++;
        if (op == OP_QUERY)
            expected_faces.push_back(fixed ? fixed_res : predict_faces(x, y, z));
        else
            store_voxel(x, y, z, solid);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_faces.size() != 0) @(posedge i_clk);
    endtask

    t_stim_row directed_rows [22] = '{
        '{OP_QUERY,  0,  0,  0, 1'b0, 1'b1, 1'b0, 6'h3f},
        '{OP_QUERY, 63, 63, 63, 1'b1, 1'b1, 1'b0, 6'h3f},
        '{OP_WRITE,  0,  0,  0, 1'b1, 1'b0, 1'b0, 6'h00},
        '{OP_QUERY,  0,  0,  0, 1'b0, 1'b1, 1'b1, 6'h3f},
        '{OP_WRITE, 63, 63, 63, 1'b1, 1'b0, 1'b0, 6'h00},
        '{OP_QUERY, 63, 63, 63, 1'b0, 1'b1, 1'b1, 6'h3f},
        '{OP_QUERY,  1,  0,  0, 1'b0, 1'b0, 1'b0, 6'h00},
        '{OP_WRITE, 11, 20, 30, 1'b1, 1'b0, 1'b0, 6'h00},
        '{OP_WRITE,  9, 20, 30, 1'b1, 1'b0, 1'b0, 6'h00},
        '{OP_WRITE, 10, 21, 30, 1'b1, 1'b0, 1'b0, 6'h00},
        '{OP_WRITE, 10, 19, 30, 1'b1, 1'b0, 1'b0, 6'h00},
        '{OP_WRITE, 10, 20, 31, 1'b1, 1'b0, 1'b0, 6'h00},
        '{OP_WRITE, 10, 20, 29, 1'b1, 1'b0, 1'b0, 6'h00},
        '{OP_QUERY, 10, 20, 30, 1'b0, 1'b1, 1'b0, 6'h00},
        '{OP_WRITE, 10, 20, 30, 1'b1, 1'b0, 1'b0, 6'h00},
        '{OP_QUERY, 10, 20, 30, 1'b0, 1'b1, 1'b1, 6'h00},
        '{OP_WRITE, 11, 20, 30, 1'b0, 1'b0, 1'b0, 6'h00},
        '{OP_QUERY, 10, 20, 30, 1'b0, 1'b1, 1'b1, 6'h01},
        '{OP_WRITE, 10, 20, 29, 1'b0, 1'b0, 1'b0, 6'h00},
        '{OP_QUERY, 10, 20, 30, 1'b1, 1'b1, 1'b1, 6'h21},
        '{OP_QUERY,  0, 63,  0, 1'b1, 1'b0, 1'b0, 6'h00},
        '{OP_QUERY, 63,  0, 63, 1'b0, 1'b0, 1'b0, 6'h00}
    };

    // stimulus and end of run
    initial begin
        int           bx, by, bz, x, y, z;
        logic         op, solid;
        t_face_result fixed_res;

        foreach (occ_rows[i]) occ_rows[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            fixed_res.is_solid  = directed_rows[i].e_solid;
            fixed_res.face_mask = directed_rows[i].e_mask;
            send_word(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].z, directed_rows[i].solid,
                      directed_rows[i].fixed, fixed_res);
        end
        drain_results();

        bx = 0; by = 0; bz = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 64 == 0) begin
                bx = pick_base();
                by = pick_base();
                bz = pick_base();
            end
            if (n == RANDOM_WORDS / 2)
                drain_results();
            if ($urandom_range(0, 9) < 8) begin
                x = bx + $urandom_range(0, 3);
                y = by + $urandom_range(0, 3);
                z = bz + $urandom_range(0, 3);
            end else begin
                x = $urandom_range(0, 63);
                y = $urandom_range(0, 63);
                z = $urandom_range(0, 63);
            end
            if ($urandom_range(0, 99) < 55) begin
                op    = OP_WRITE;
                solid = ($urandom_range(0, 9) < 7);
            end else begin
                op    = OP_QUERY;
                solid = 1'($urandom_range(0, 1));
            end
            send_word(op, x, y, z, solid, 1'b0, '0);
        end
        drain_results();
        repeat (30) @(posedge i_clk);

        if (faults == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial begin
        int           stall;
        t_face_result got;
        t_face_result want;

        wait (i_rst_n === 1'b1);
        forever begin
            stall = ((results_seen % 150) < 30) ? 0 : $urandom_range(0, 4);
            if (results_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (o_m_tvalid !== 1'b1) @(posedge i_clk);
            got = o_m_tdata[6:0];
            results_seen++;
            if (expected_faces.size() == 0) begin
                note_fault($sformatf("unexpected word is_solid=%0b face_mask=%02h",
                                     got.is_solid, got.face_mask));
            end else begin
                want = expected_faces.pop_front();
                if (got.is_solid !== want.is_solid)
                    note_fault($sformatf("word %0d is_solid exp %0b got %0b",
                                         results_seen, want.is_solid, got.is_solid));
                if (got.face_mask !== want.face_mask)
                    note_fault($sformatf("word %0d face_mask exp %02h got %02h",
                                         results_seen, want.face_mask, got.face_mask));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready === 1'b1) || (m_tready && o_m_tvalid === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
